### hdl/irpfd_pkg.sv
// Shared types, constants and helpers for the IR pulse frame decoder.
`timescale 1ns / 1ps

package irpfd_pkg;

  localparam int CODE_BITS_DEF = 6;
  localparam int CODE_W        = 6;
  localparam int BLINK_W       = 3;
  localparam int WIN_W         = 8;
  localparam int CFG_IDX_W     = 2;

  // stream widths: tdata rounded up to whole bytes
  localparam int S_DATA_W = 8;
  localparam int M_DATA_W = 16;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_START_WINDOW     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_WINDOW       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_EDGE_WINDOW  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_CHECK_WINDOW = 2'd3;

  localparam logic [WIN_W-1:0] START_WINDOW_RST     = 8'd62;
  localparam logic [WIN_W-1:0] GAP_WINDOW_RST       = 8'd156;
  localparam logic [WIN_W-1:0] BIT_EDGE_WINDOW_RST  = 8'd75;
  localparam logic [WIN_W-1:0] BIT_CHECK_WINDOW_RST = 8'd56;

  typedef enum logic [1:0] {
    PH_START,
    PH_GAP,
    PH_BIT_EDGE,
    PH_BIT_CHECK
  } phase_t;

  localparam logic [CODE_W-1:0] CODE_BLINK_1 = 6'd18;
  localparam logic [CODE_W-1:0] CODE_BLINK_2 = 6'd19;
  localparam logic [CODE_W-1:0] CODE_BLINK_3 = 6'd16;
  localparam logic [CODE_W-1:0] CODE_BLINK_4 = 6'd17;

  function automatic logic [BLINK_W-1:0] blinks_for(input logic [CODE_W-1:0] code);
    logic [BLINK_W-1:0] b;
    case (code)
      CODE_BLINK_1: b = 3'd1;
      CODE_BLINK_2: b = 3'd2;
      CODE_BLINK_3: b = 3'd3;
      CODE_BLINK_4: b = 3'd4;
      default:      b = 3'd0;
    endcase
    return b;
  endfunction

endpackage

### hdl/ir_pulse_frame_decoder_top.sv
// IR pulse frame decoder: windowed falling-edge timing, six-bit code out.
// A result is registered onto m_tvalid in the cycle after the sample that ends the frame.
// Throughput: one pin sample per cycle while s_tready is high; state updates in the cycle of the transfer.
// Only a stalled output register holds off input (s_tready = output free or draining).
// Reset (rst, synchronous): windows back to defaults, phase awaits a start edge,
// tick counter, level history, bit position and code cleared; output emptied.
`timescale 1ns / 1ps

module ir_pulse_frame_decoder_top #(
  parameter int CODE_BITS = irpfd_pkg::CODE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // config write port
  input  logic                           cfg_we,
  input  logic [irpfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [irpfd_pkg::WIN_W-1:0]     cfg_data,
  // pin samples
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [irpfd_pkg::S_DATA_W-1:0]  s_tdata,  // [0] pin_level, [7:1] zero
  // results
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [irpfd_pkg::M_DATA_W-1:0]  m_tdata   // [5:0] code, [8:6] blink_count, [15:9] zero
);

  import irpfd_pkg::*;

  localparam int POS_W = (CODE_BITS > 1) ? $clog2(CODE_BITS) : 1;

  logic [WIN_W-1:0] start_window;
  logic [WIN_W-1:0] gap_window;
  logic [WIN_W-1:0] bit_edge_window;
  logic [WIN_W-1:0] bit_check_window;

  phase_t             phase, phase_next;
  logic [WIN_W-1:0]   window_ticks, window_ticks_next;
  logic               previous_level, previous_level_next;
  logic [POS_W-1:0]   bit_position, bit_position_next;
  logic [CODE_W-1:0]  code_acc, code_acc_next;

  logic               emit;
  logic [CODE_W-1:0]  emit_code;

  logic               s_xfer;
  logic               lvl;
  logic               edge_det;
  logic [WIN_W-1:0]   limit;
  logic               win_open;
  logic [POS_W:0]     pos_inc;
  logic               last_bit;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_window     <= START_WINDOW_RST;
      gap_window       <= GAP_WINDOW_RST;
      bit_edge_window  <= BIT_EDGE_WINDOW_RST;
      bit_check_window <= BIT_CHECK_WINDOW_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_WINDOW:     start_window     <= cfg_data;
        REG_GAP_WINDOW:       gap_window       <= cfg_data;
        REG_BIT_EDGE_WINDOW:  bit_edge_window  <= cfg_data;
        REG_BIT_CHECK_WINDOW: bit_check_window <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_tready = !m_tvalid || m_tready;
  assign s_xfer   = s_tvalid && s_tready;
  assign lvl      = s_tdata[0];
  assign edge_det = previous_level && !lvl;

  always_comb begin
    case (phase)
      PH_START:     limit = start_window;
      PH_GAP:       limit = gap_window;
      PH_BIT_EDGE:  limit = bit_edge_window;
      PH_BIT_CHECK: limit = bit_check_window;
      default:      limit = start_window;
    endcase
  end

  assign win_open = !edge_det && (window_ticks < limit);
  assign pos_inc  = {1'b0, bit_position} + (POS_W+1)'(1);
  assign last_bit = pos_inc >= (POS_W+1)'(CODE_BITS);

  // next state
  always_comb begin
    phase_next          = phase;
    window_ticks_next   = window_ticks;
    previous_level_next = previous_level;
    bit_position_next   = bit_position;
    code_acc_next       = code_acc;
    if (win_open) begin
      window_ticks_next   = window_ticks + WIN_W'(1);
      previous_level_next = lvl;
    end else begin
      window_ticks_next   = '0;
      previous_level_next = 1'b0;
      case (phase)
        PH_START: begin
          if (edge_det) phase_next = PH_GAP;
        end
        PH_GAP: begin
          if (edge_det) begin
            phase_next = PH_START;
          end else begin
            phase_next        = PH_BIT_EDGE;
            bit_position_next = '0;
            code_acc_next     = '0;
          end
        end
        PH_BIT_EDGE: begin
          if (edge_det) begin
            phase_next = PH_BIT_CHECK;
          end else begin
            code_acc_next = '0;
            if (last_bit) begin
              phase_next        = PH_START;
              bit_position_next = '0;
            end else begin
              phase_next        = PH_BIT_EDGE;
              bit_position_next = pos_inc[POS_W-1:0];
            end
          end
        end
        PH_BIT_CHECK: begin
          if (edge_det) begin
            code_acc_next = '0;
          end else if (!lvl && (32'(bit_position) < CODE_W)) begin
            code_acc_next = code_acc | (CODE_W'(1) << bit_position);
          end
          if (last_bit) begin
            phase_next        = PH_START;
            bit_position_next = '0;
            code_acc_next     = '0;
          end else begin
            phase_next        = PH_BIT_EDGE;
            bit_position_next = pos_inc[POS_W-1:0];
          end
        end
        default: phase_next = PH_START;
      endcase
    end
  end

  // result of this sample, if any
  always_comb begin
    emit      = 1'b0;
    emit_code = '0;
    if (!win_open) begin
      case (phase)
        PH_START:     emit = !edge_det;
        PH_GAP:       emit = edge_det;
        PH_BIT_EDGE:  emit = !edge_det && last_bit;
        PH_BIT_CHECK: begin
          emit = last_bit;
          if (edge_det) begin
            emit_code = '0;
          end else if (!lvl && (32'(bit_position) < CODE_W)) begin
            emit_code = code_acc | (CODE_W'(1) << bit_position);
          end else begin
            emit_code = code_acc;
          end
        end
        default: emit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_START;
      window_ticks   <= '0;
      previous_level <= 1'b0;
      bit_position   <= '0;
      code_acc       <= '0;
    end else if (s_xfer) begin
      phase          <= phase_next;
      window_ticks   <= window_ticks_next;
      previous_level <= previous_level_next;
      bit_position   <= bit_position_next;
      code_acc       <= code_acc_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_xfer && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s_xfer && emit) begin
      m_tdata <= {(M_DATA_W-CODE_W-BLINK_W)'(0), blinks_for(emit_code), emit_code};
    end
  end

`ifndef ASSERT_OFF
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    32'(bit_position) < CODE_BITS)
    else $error("bit position past last code bit");

  a_blink_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[8:6] != 3'd0) |-> (m_tdata[5:2] == 4'b0100))
    else $error("blink count set for a code outside the blink set");

  a_window_restart: assert property (@(posedge clk) disable iff (rst)
    (phase != $past(phase)) |-> (window_ticks == '0) && !previous_level)
    else $error("phase change without a fresh window");

  a_no_result_mid_window: assert property (@(posedge clk) disable iff (rst)
    s_xfer && win_open |=> !m_tvalid)
    else $error("result produced inside an open window");
`endif

endmodule
